@@ rtl/core/ma_rss_pkg.sv @@
// Shared widths, register indexes and handoff types for the residual sum-of-squares block.
`timescale 1ns / 1ps
`default_nettype none
package ma_rss_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEFF_W    = 16;
    localparam int RESID_W    = 32;
    localparam int PROD_W     = COEFF_W + RESID_W;
    localparam int RND_SHIFT  = 14;
    localparam int RND_W      = PROD_W + 1 - RND_SHIFT;
    localparam int ACC_W      = 36;
    localparam int CAP_W      = 24;
    localparam int CAP_RES_W  = CAP_W + 8;
    localparam int SUM_W      = CAP_W + 16;
    localparam int SQ_W       = 63;
    localparam int OUT_SUM_W  = 63;
    localparam int ORDER_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int NUM_COEFF  = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_ORDER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF0 = 3'd2;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd1;
    localparam logic [CAP_W-1:0]   CAP_RESET   = 24'hFF_FFFF;

    localparam logic signed [PROD_W:0]  RND_BIAS = 49'sd8192;
    localparam logic signed [ACC_W-1:0] RES_MAX  = 36'sd2147483647;
    localparam logic signed [ACC_W-1:0] RES_MIN  = -36'sd2147483648;

    typedef struct packed {
        logic                    valid;
        logic                    exceeded;
        logic signed [ACC_W-1:0] acc;
    } t_token;

    typedef struct packed {
        logic                      valid;
        logic signed [RESID_W-1:0] value;
    } t_hist;

endpackage
`default_nettype wire

@@ rtl/core/ma_rss_cell.sv @@
// One history cell: holds one earlier residual and adds its weighted term to a passing partial.
`timescale 1ns / 1ps
`default_nettype none
module ma_rss_cell (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_clear,
    input  wire logic                                     i_shift,
    input  wire ma_rss_pkg::t_hist                        i_hist,
    output ma_rss_pkg::t_hist                             o_hist,
    input  wire logic signed [ma_rss_pkg::COEFF_W-1:0]    i_coeff,
    input  wire logic                                     i_en,
    input  wire logic [ma_rss_pkg::CAP_RES_W-1:0]         i_cap_res,
    input  wire ma_rss_pkg::t_token                       i_tok,
    output ma_rss_pkg::t_token                            o_tok
);

    localparam int ACC_W  = ma_rss_pkg::ACC_W;
    localparam int RND_W  = ma_rss_pkg::RND_W;
    localparam int PROD_W = ma_rss_pkg::PROD_W;

    logic                                     r_hval;
    logic signed [ma_rss_pkg::RESID_W-1:0]    r_hvalue;
    logic signed [RND_W-1:0]                  r_rnd;
    logic                                     r_tok_valid;
    logic                                     r_tok_exc;
    logic signed [ACC_W-1:0]                  r_tok_acc;

    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W:0]   w_biased;
    logic signed [ACC_W-1:0]  w_rnd_ext;
    logic signed [ACC_W-1:0]  w_sum;
    logic signed [ACC_W-1:0]  w_cap;
    logic                     w_apply;
    logic                     w_over;

    assign w_prod    = i_coeff * r_hvalue;
    assign w_biased  = {w_prod[PROD_W-1], w_prod} + ma_rss_pkg::RND_BIAS;
    assign w_rnd_ext = {{(ACC_W-RND_W){r_rnd[RND_W-1]}}, r_rnd};
    assign w_sum     = i_tok.acc + w_rnd_ext;
    assign w_cap     = {{(ACC_W-ma_rss_pkg::CAP_RES_W){1'b0}}, i_cap_res};
    assign w_over    = (w_sum > w_cap) || (w_sum < -w_cap);
    assign w_apply   = i_tok.valid && !i_tok.exceeded && i_en && r_hval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hval      <= 1'b0;
            r_tok_valid <= 1'b0;
            r_tok_exc   <= 1'b0;
        end else begin
            if (i_clear) begin
                r_hval <= 1'b0;
            end else if (i_shift) begin
                r_hval <= i_hist.valid;
            end
            r_tok_valid <= i_tok.valid;
            r_tok_exc   <= i_tok.exceeded || (w_apply && w_over);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_hvalue <= i_hist.value;
        end
        r_rnd     <= w_biased[PROD_W:ma_rss_pkg::RND_SHIFT];
        r_tok_acc <= w_apply ? w_sum : i_tok.acc;
    end

    assign o_hist.valid   = r_hval;
    assign o_hist.value   = r_hvalue;
    assign o_tok.valid    = r_tok_valid;
    assign o_tok.exceeded = r_tok_exc;
    assign o_tok.acc      = r_tok_acc;

endmodule
`default_nettype wire

@@ rtl/core/ma_residual_sum_of_squares.sv @@
// Top level of the moving-average residual and running sum-of-squares block.
//
// Input channel i_valid/o_ready carries one request: i_sample (Q7.8) and i_first,
// which starts a new sequence and clears history, sum and capped flag.
// Output channel o_valid/i_ready returns one result per request: o_residual,
// o_sum_squares and o_capped.
// Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data; the user
// must write it only while idle (the block does not enforce it): index 0 order,
// 1 cap, 2..7 coefficients one to six steps back. Each request walks a row of
// MAX_ORDER history cells, one cell per cycle, then is squared, then accumulated
// and checked against the cap. A frozen request (capped, not first) skips the
// cells and returns a zero residual.
// One request is in flight at a time; the result sits in an output register,
// so a stalled receiver holds only that register while the next request computes.
// The result of a new request waits in the last state until the register is free.
// Synchronous reset clears the history, sum, flag and handshakes and loads the
// register defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module ma_residual_sum_of_squares #(
    parameter int MAX_ORDER = 6
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_valid,
    output logic                                           o_ready,
    input  wire logic signed [ma_rss_pkg::SAMPLE_W-1:0]    i_sample,
    input  wire logic                                      i_first,
    output logic                                           o_valid,
    input  wire logic                                      i_ready,
    output logic signed [ma_rss_pkg::RESID_W-1:0]          o_residual,
    output logic [ma_rss_pkg::OUT_SUM_W-1:0]               o_sum_squares,
    output logic                                           o_capped,
    input  wire logic                                      i_cfg_we,
    input  wire logic [ma_rss_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [ma_rss_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int ACC_W   = ma_rss_pkg::ACC_W;
    localparam int RESID_W = ma_rss_pkg::RESID_W;
    localparam int SUM_W   = ma_rss_pkg::SUM_W;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_WAIT  = 7'b0000010,
        ST_CHAIN = 7'b0000100,
        ST_SQR   = 7'b0001000,
        ST_SUM   = 7'b0010000,
        ST_OUT   = 7'b0100000,
        ST_SPARE = 7'b1000000
    } t_state;

    t_state                                       r_state;
    logic [ma_rss_pkg::ORDER_W-1:0]               r_order;
    logic [ma_rss_pkg::CAP_W-1:0]                 r_cap;
    logic signed [ma_rss_pkg::COEFF_W-1:0]        r_coeff [ma_rss_pkg::NUM_COEFF];
    logic signed [ma_rss_pkg::SAMPLE_W-1:0]       r_sample;
    logic                                         r_launch_valid;
    logic signed [RESID_W-1:0]                    r_resid;
    logic                                         r_exc;
    logic [ma_rss_pkg::SQ_W-1:0]                  r_sq;
    logic [SUM_W-1:0]                             r_sum;
    logic                                         r_capped;
    logic signed [RESID_W-1:0]                    r_res_out;
    logic                                         r_out_valid;
    logic signed [RESID_W-1:0]                    r_out_resid;
    logic [SUM_W-1:0]                             r_out_sum;
    logic                                         r_out_capped;

    ma_rss_pkg::t_token                           w_tok [MAX_ORDER+1];
    ma_rss_pkg::t_hist                            w_hist [MAX_ORDER];
    logic [ma_rss_pkg::CAP_RES_W-1:0]             w_cap_res;
    logic [SUM_W-1:0]                             w_cap_sum;
    logic                                         w_accept;
    logic                                         w_clear;
    logic                                         w_shift;
    logic signed [RESID_W-1:0]                    w_sat;
    logic signed [2*RESID_W-1:0]                  w_sq;
    logic [2*RESID_W-1:0]                         w_sum_new;

    assign o_ready   = (r_state == ST_IDLE);
    assign w_accept  = i_valid && o_ready;
    assign w_clear   = w_accept && i_first;
    assign w_shift   = (r_state == ST_SUM) && !r_exc;
    assign w_cap_res = {r_cap, 8'b0};
    assign w_cap_sum = {r_cap, 16'b0};

    assign w_tok[0].valid    = r_launch_valid;
    assign w_tok[0].exceeded = 1'b0;
    assign w_tok[0].acc      = {{(ACC_W-ma_rss_pkg::SAMPLE_W){r_sample[ma_rss_pkg::SAMPLE_W-1]}},
                                r_sample};

    assign w_hist[0].valid = 1'b1;
    assign w_hist[0].value = r_resid;

    for (genvar j = 0; j < MAX_ORDER; j++) begin : g_cell
        logic w_en;
        assign w_en = (int'(r_order) > j);
        if (j < MAX_ORDER - 1) begin : g_mid
            ma_rss_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_clear   (w_clear),
                .i_shift   (w_shift),
                .i_hist    (w_hist[j]),
                .o_hist    (w_hist[j+1]),
                .i_coeff   (r_coeff[j]),
                .i_en      (w_en),
                .i_cap_res (w_cap_res),
                .i_tok     (w_tok[j]),
                .o_tok     (w_tok[j+1])
            );
        end else begin : g_last
            ma_rss_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_clear   (w_clear),
                .i_shift   (w_shift),
                .i_hist    (w_hist[j]),
                .o_hist    (),
                .i_coeff   (r_coeff[j]),
                .i_en      (w_en),
                .i_cap_res (w_cap_res),
                .i_tok     (w_tok[j]),
                .o_tok     (w_tok[j+1])
            );
        end
    end

    always_comb begin
        if (w_tok[MAX_ORDER].acc > ma_rss_pkg::RES_MAX) begin
            w_sat = ma_rss_pkg::RES_MAX[RESID_W-1:0];
        end else if (w_tok[MAX_ORDER].acc < ma_rss_pkg::RES_MIN) begin
            w_sat = ma_rss_pkg::RES_MIN[RESID_W-1:0];
        end else begin
            w_sat = w_tok[MAX_ORDER].acc[RESID_W-1:0];
        end
    end

    assign w_sq      = r_resid * r_resid;
    assign w_sum_new = {1'b0, r_sq} + {{(2*RESID_W-SUM_W){1'b0}}, r_sum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ma_rss_pkg::ORDER_RESET;
            r_cap   <= ma_rss_pkg::CAP_RESET;
            for (int k = 0; k < ma_rss_pkg::NUM_COEFF; k++) begin
                r_coeff[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index) inside
                ma_rss_pkg::CFG_ORDER: begin
                    r_order <= i_cfg_data[ma_rss_pkg::ORDER_W-1:0];
                end
                ma_rss_pkg::CFG_CAP: begin
                    r_cap <= i_cfg_data[ma_rss_pkg::CAP_W-1:0];
                end
                default: begin
                    r_coeff[i_cfg_index - ma_rss_pkg::CFG_COEFF0] <=
                        i_cfg_data[ma_rss_pkg::COEFF_W-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_launch_valid <= 1'b0;
            r_out_valid    <= 1'b0;
            r_sum          <= '0;
            r_capped       <= 1'b0;
        end else begin
            r_launch_valid <= (r_state == ST_WAIT);
            if ((r_state == ST_OUT) && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        if (i_first) begin
                            r_sum    <= '0;
                            r_capped <= 1'b0;
                        end
                        if (r_capped && !i_first) begin
                            r_res_out <= '0;
                            r_state   <= ST_OUT;
                        end else begin
                            r_sample <= i_sample;
                            r_state  <= ST_WAIT;
                        end
                    end
                end
                ST_WAIT: begin
                    r_state <= ST_CHAIN;
                end
                ST_CHAIN: begin
                    if (w_tok[MAX_ORDER].valid) begin
                        r_resid <= w_sat;
                        r_exc   <= w_tok[MAX_ORDER].exceeded;
                        r_state <= ST_SQR;
                    end
                end
                ST_SQR: begin
                    r_sq    <= w_sq[ma_rss_pkg::SQ_W-1:0];
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    if (r_exc) begin
                        r_sum     <= w_cap_sum;
                        r_capped  <= 1'b1;
                        r_res_out <= '0;
                    end else begin
                        if (w_sum_new > {{(2*RESID_W-SUM_W){1'b0}}, w_cap_sum}) begin
                            r_sum    <= w_cap_sum;
                            r_capped <= 1'b1;
                        end else begin
                            r_sum <= w_sum_new[SUM_W-1:0];
                        end
                        r_res_out <= r_resid;
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_resid  <= r_res_out;
                        r_out_sum    <= r_sum;
                        r_out_capped <= r_capped;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_residual    = r_out_resid;
    assign o_sum_squares = {{(ma_rss_pkg::OUT_SUM_W-SUM_W){1'b0}}, r_out_sum};
    assign o_capped      = r_out_capped;

`ifndef SYNTH
    a_launch_in_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_launch_valid |-> r_state == ST_CHAIN)
        else $error("partial launched outside the cell walk");

    a_tail_in_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[MAX_ORDER].valid |-> r_state == ST_CHAIN)
        else $error("partial left the last cell outside the cell walk");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_WAIT) || (r_state == ST_OUT))
        else $error("accepted request did not start");
`endif

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the moving-average residual sum-of-squares block.
`timescale 1ns / 1ps
module testbench;

    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_PHASES = 14;
    localparam int ITEMS_PER_PHASE = 75;

    typedef struct packed {
        logic signed [ma_rss_pkg::RESID_W-1:0] residual;
        logic [ma_rss_pkg::OUT_SUM_W-1:0]      sum_sq;
        logic                                  capped;
    } t_result;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} t_row_kind;

    typedef struct {
        t_row_kind                              kind;
        logic [ma_rss_pkg::CFG_IDX_W-1:0]       idx;
        logic [ma_rss_pkg::CFG_DATA_W-1:0]      data;
        logic signed [ma_rss_pkg::SAMPLE_W-1:0] smp;
        logic                                   frst;
        logic                                   typed;
        t_result                                want;
    } t_stim_row;

    logic                                      i_clk = 1'b0;
    logic                                      i_rst_n = 1'b0;
    logic                                      i_valid = 1'b0;
    logic signed [ma_rss_pkg::SAMPLE_W-1:0]    i_sample = '0;
    logic                                      i_first = 1'b0;
    logic                                      i_ready = 1'b0;
    logic                                      i_cfg_we = 1'b0;
    logic [ma_rss_pkg::CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic [ma_rss_pkg::CFG_DATA_W-1:0]         i_cfg_data = '0;
    logic                                      o_ready;
    logic                                      o_valid;
    logic signed [ma_rss_pkg::RESID_W-1:0]     o_residual;
    logic [ma_rss_pkg::OUT_SUM_W-1:0]          o_sum_squares;
    logic                                      o_capped;

    // predictor state and register copies
    logic [ma_rss_pkg::ORDER_W-1:0]            cfg_order = ma_rss_pkg::ORDER_RESET;
    logic [ma_rss_pkg::CAP_W-1:0]              cfg_cap = ma_rss_pkg::CAP_RESET;
    logic signed [ma_rss_pkg::COEFF_W-1:0]     cfg_coeff [ma_rss_pkg::NUM_COEFF];
    logic signed [ma_rss_pkg::RESID_W-1:0]     resid_ring [ma_rss_pkg::NUM_COEFF];
    int unsigned                               ring_wr = 0;
    int unsigned                               ring_fill = 0;
    logic [63:0]                               sq_total = '0;
    logic                                      seq_capped = 1'b0;

    t_result                                   expected_rss [$];
    t_stim_row                                 plan [$];
    int                                        error_count = 0;
    int                                        burst_left = 0;
    int                                        cycle_count = 0;
    logic [15:0]                               ready_pattern = 16'hFFFF;
    logic [5:0]                                ready_tick = '0;

    ma_residual_sum_of_squares u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample      (i_sample),
        .i_first       (i_first),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_residual    (o_residual),
        .o_sum_squares (o_sum_squares),
        .o_capped      (o_capped),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (ready_tick == '0) begin
            case ($urandom_range(0, 3))
                0: ready_pattern <= 16'hFFFF;
                1: ready_pattern <= 16'($urandom);
                2: ready_pattern <= 16'($urandom & $urandom | 16'h0001);
                default: ready_pattern <= 16'($urandom | $urandom);
            endcase
        end
        i_ready <= ready_pattern[ready_tick[3:0]];
        ready_tick <= ready_tick + 1'b1;
    end

    task automatic log_error(input string msg);
        $display("ERROR @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_rss.size() == 0) begin
                log_error($sformatf("unexpected result residual=%0d", o_residual));
            end else begin
                want = expected_rss.pop_front();
                if (o_residual !== want.residual)
                    log_error($sformatf("residual got %0d expected %0d",
                                        o_residual, want.residual));
                if (o_sum_squares !== want.sum_sq)
                    log_error($sformatf("sum_squares got %0h expected %0h",
                                        o_sum_squares, want.sum_sq));
                if (o_capped !== want.capped)
                    log_error($sformatf("capped got %0b expected %0b",
                                        o_capped, want.capped));
            end
        end
    end

    function automatic t_result predict_rss(
        input logic signed [ma_rss_pkg::SAMPLE_W-1:0] smp,
        input logic frst);
        longint      acc;
        longint      prod;
        longint      mag;
        longint      lim_res;
        longint      r;
        logic [63:0] lim_sum;
        int unsigned ord;
        int unsigned terms;
        int unsigned pos;
        int unsigned j;
        logic        over;
        t_result     res;
        acc = longint'(smp);
        lim_res = longint'(cfg_cap) << 8;
        lim_sum = 64'(cfg_cap) << 16;
        over = 1'b0;
        res.residual = '0;
        if (frst) begin
            foreach (resid_ring[k]) resid_ring[k] = '0;
            ring_wr = 0;
            ring_fill = 0;
            sq_total = '0;
            seq_capped = 1'b0;
        end
        if (!seq_capped) begin
            ord = (cfg_order > ma_rss_pkg::NUM_COEFF) ? ma_rss_pkg::NUM_COEFF : cfg_order;
            terms = (ord < ring_fill) ? ord : ring_fill;
            for (j = 1; j <= terms && !over; j++) begin
                pos = (ring_wr + ma_rss_pkg::NUM_COEFF - j) % ma_rss_pkg::NUM_COEFF;
                prod = longint'(cfg_coeff[j-1]) * longint'(resid_ring[pos]);
                acc += (prod + 8192) >>> 14;
                mag = (acc < 0) ? -acc : acc;
                if (mag > lim_res) over = 1'b1;
            end
            if (over) begin
                sq_total = lim_sum;
                seq_capped = 1'b1;
            end else begin
                r = acc;
                if (r > longint'(ma_rss_pkg::RES_MAX)) r = longint'(ma_rss_pkg::RES_MAX);
                if (r < longint'(ma_rss_pkg::RES_MIN)) r = longint'(ma_rss_pkg::RES_MIN);
                resid_ring[ring_wr] = r[ma_rss_pkg::RESID_W-1:0];
                ring_wr = (ring_wr + 1) % ma_rss_pkg::NUM_COEFF;
                if (ring_fill < ma_rss_pkg::NUM_COEFF) ring_fill++;
                sq_total = sq_total + 64'(r * r);
                if (sq_total > lim_sum) begin
                    sq_total = lim_sum;
                    seq_capped = 1'b1;
                end
                res.residual = r[ma_rss_pkg::RESID_W-1:0];
            end
        end
        res.sum_sq = sq_total[ma_rss_pkg::OUT_SUM_W-1:0];
        res.capped = seq_capped;
        return res;
    endfunction

    function automatic t_stim_row cfg_row(input logic [ma_rss_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [ma_rss_pkg::CFG_DATA_W-1:0] data);
        t_stim_row row;
        row = '{ROW_WRITE, idx, data, '0, 1'b0, 1'b0, '0};
        return row;
    endfunction

    function automatic t_stim_row smp_row(input logic signed [ma_rss_pkg::SAMPLE_W-1:0] smp,
                                          input logic frst);
        t_stim_row row;
        row = '{ROW_SAMPLE, '0, '0, smp, frst, 1'b0, '0};
        return row;
    endfunction

    function automatic t_stim_row known_row(
        input logic signed [ma_rss_pkg::SAMPLE_W-1:0] smp,
        input logic frst,
        input logic signed [ma_rss_pkg::RESID_W-1:0] r,
        input logic [ma_rss_pkg::OUT_SUM_W-1:0] s,
        input logic c);
        t_stim_row row;
        row = '{ROW_SAMPLE, '0, '0, smp, frst, 1'b1, '{r, s, c}};
        return row;
    endfunction

    task automatic write_cfg(input logic [ma_rss_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ma_rss_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            ma_rss_pkg::CFG_ORDER: cfg_order = data[ma_rss_pkg::ORDER_W-1:0];
            ma_rss_pkg::CFG_CAP:   cfg_cap = data[ma_rss_pkg::CAP_W-1:0];
            default: cfg_coeff[idx - ma_rss_pkg::CFG_COEFF0] = data[ma_rss_pkg::COEFF_W-1:0];
        endcase
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_rss.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic send_request(input t_stim_row row);
        int      gap;
        t_result predicted;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_sample <= row.smp;
        i_first <= row.frst;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        burst_left--;
        predicted = predict_rss(row.smp, row.frst);
        expected_rss.push_back(row.typed ? row.want : predicted);
    endtask

    initial begin
        t_stim_row                              row;
        logic [ma_rss_pkg::CFG_DATA_W-1:0]      data;
        logic signed [ma_rss_pkg::COEFF_W-1:0]  coef;
        logic signed [ma_rss_pkg::SAMPLE_W-1:0] smp;
        logic [ma_rss_pkg::CAP_W-1:0]           cap;
        logic                                   start_seq;
        int                                     seq_len;
        int                                     n_items;
        foreach (cfg_coeff[k]) cfg_coeff[k] = '0;
        foreach (resid_ring[k]) resid_ring[k] = '0;

        plan.push_back(known_row(16'sh7FFF, 1'b1, 32767, 1073676289, 1'b0));
        plan.push_back(known_row(16'sh8000, 1'b0, -32768, 2147418113, 1'b0));
        plan.push_back(cfg_row(ma_rss_pkg::CFG_COEFF0, 24'h007FFF));
        plan.push_back(cfg_row(ma_rss_pkg::CFG_COEFF0 + 3'd1, 24'hFF8000));
        plan.push_back(cfg_row(ma_rss_pkg::CFG_COEFF0 + 3'd2, 24'h002000));
        plan.push_back(cfg_row(ma_rss_pkg::CFG_COEFF0 + 3'd3, 24'h00E000));
        plan.push_back(cfg_row(ma_rss_pkg::CFG_COEFF0 + 3'd4, 24'h000800));
        plan.push_back(cfg_row(ma_rss_pkg::CFG_COEFF0 + 3'd5, 24'h00F123));
        plan.push_back(cfg_row(ma_rss_pkg::CFG_ORDER, 24'h000006));
        plan.push_back(smp_row(16'sh0100, 1'b1));
        plan.push_back(smp_row(16'sh7FFF, 1'b0));
        plan.push_back(smp_row(16'sh8000, 1'b0));
        plan.push_back(smp_row(16'sh1234, 1'b0));
        plan.push_back(smp_row(16'shFEDC, 1'b0));
        plan.push_back(smp_row(16'sh0001, 1'b0));
        plan.push_back(smp_row(16'sh8000, 1'b0));
        plan.push_back(smp_row(16'sh7FFF, 1'b0));
        plan.push_back(cfg_row(ma_rss_pkg::CFG_ORDER, 24'h000000));
        plan.push_back(smp_row(16'sh0042, 1'b0));
        plan.push_back(known_row(16'sh4000, 1'b1, 16384, 268435456, 1'b0));
        plan.push_back(known_row(16'sh8001, 1'b0, -32767, 1342111745, 1'b0));
        plan.push_back(cfg_row(ma_rss_pkg::CFG_ORDER, 24'h000007));
        plan.push_back(smp_row(16'sh0200, 1'b1));
        plan.push_back(smp_row(16'sh0300, 1'b0));
        plan.push_back(smp_row(16'sh0300, 1'b0));
        plan.push_back(cfg_row(ma_rss_pkg::CFG_CAP, 24'h000000));
        plan.push_back(known_row(16'sh0000, 1'b1, 0, 0, 1'b0));
        plan.push_back(known_row(16'sh0001, 1'b0, 0, 0, 1'b1));
        plan.push_back(known_row(16'sh7FFF, 1'b0, 0, 0, 1'b1));
        plan.push_back(known_row(16'sh0005, 1'b1, 5, 0, 1'b1));
        plan.push_back(cfg_row(ma_rss_pkg::CFG_CAP, 24'h000001));
        plan.push_back(known_row(16'sh0100, 1'b1, 256, 65536, 1'b0));
        plan.push_back(known_row(16'sh0000, 1'b0, 0, 65536, 1'b1));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[n]) begin
            if (plan[n].kind == ROW_WRITE) begin
                wait_idle();
                write_cfg(plan[n].idx, plan[n].data);
            end else begin
                send_request(plan[n]);
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_idle();
            data = 24'($urandom);
            data[ma_rss_pkg::ORDER_W-1:0] = ($urandom_range(0, 7) == 0)
                                            ? 3'($urandom_range(0, 7))
                                            : 3'($urandom_range(1, 6));
            write_cfg(ma_rss_pkg::CFG_ORDER, data);
            case ($urandom_range(0, 5))
                0: cap = 24'hFFFFFF;
                1: cap = '0;
                2: cap = 24'($urandom_range(1, 16));
                3: cap = 24'($urandom_range(17, 65535));
                default: cap = 24'($urandom);
            endcase
            write_cfg(ma_rss_pkg::CFG_CAP, cap);
            for (int k = 0; k < ma_rss_pkg::NUM_COEFF; k++) begin
                case ($urandom_range(0, 5))
                    0: coef = 16'sh7FFF;
                    1: coef = 16'sh8000;
                    2, 3: begin
                        coef = 16'($urandom_range(0, 4095));
                        if ($urandom_range(0, 1)) coef = -coef;
                    end
                    default: coef = 16'($urandom);
                endcase
                data = 24'($urandom);
                data[ma_rss_pkg::COEFF_W-1:0] = coef;
                write_cfg(ma_rss_pkg::CFG_COEFF0 + 3'(k), data);
            end

            n_items = 0;
            while (n_items < ITEMS_PER_PHASE) begin
                start_seq = ($urandom_range(0, 7) != 0);
                seq_len = $urandom_range(1, 16);
                if (seq_len > ITEMS_PER_PHASE - n_items) seq_len = ITEMS_PER_PHASE - n_items;
                for (int k = 0; k < seq_len; k++) begin
                    if ($urandom_range(0, 2) == 0) begin
                        smp = 16'($urandom);
                    end else begin
                        smp = 16'($urandom_range(0, 1023));
                        if ($urandom_range(0, 1)) smp = -smp;
                    end
                    row = smp_row(smp, (k == 0) && start_seq);
                    send_request(row);
                    n_items++;
                end
            end
        end

        wait_idle();
        repeat (30) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
